[design/dtpm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtpm_pkg
// Shared types and constants of the decimal trie prefix match unit.
// ---------------------------------------------------------------------------
package dtpm_pkg;

   localparam int DIGITS          = 10;
   localparam int DIGIT_BITS      = 4;
   localparam int PREFIX_ID_BITS  = 16;
   localparam int MATCH_ID_BITS   = 16;
   localparam int REQ_TDATA_BITS  = 24;
   localparam int RSP_TDATA_BITS  = 24;
   localparam int FIFO_DEPTH      = 2;

   localparam int NODE_COUNT_DEF  = 4096;
   localparam int ID_BITS_DEF     = 16;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ENG_CLEAR,
      ENG_FETCH,
      ENG_EXEC
   } eng_state_type;

   typedef struct packed {
      req_kind_type               kind;
      logic                       digit_ok;
      logic [DIGIT_BITS-1:0]      digit;
      logic                       last;
      logic [PREFIX_ID_BITS-1:0]  prefix_id;
   } cmd_type;

endpackage

[design/decimal_trie_prefix_match_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_trie_prefix_match_unit
// Ten-way decimal trie: insert prefixes digit by digit, look up numbers for
// the longest matching prefix id.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one digit per request; req_tuser selects insert or lookup,
//   req_tlast marks the final digit. Only a final digit yields a response on
//   rsp_*: the match id for a lookup (0 for none), the dropped flag for an
//   insert that found the node store full.
//   Each digit is one node row read, then the update and write back; the next
//   digit needs the link that this read returns.
//   With an empty queue and an idle engine, a final digit passes the intake
//   register, the queue and the row read; the update then loads the response
//   register, which drives rsp_tvalid.
//   After reset the engine clears both node memories, one row per cycle, over
//   all NODE_COUNT rows; up to three requests are taken meanwhile, then
//   req_tready drops until the pass ends.
//   When the receiver stalls, the response holds in its output register;
//   non-final digits keep going, a final digit waits for the register.
// ---------------------------------------------------------------------------
module decimal_trie_prefix_match_unit #(
   parameter int NODE_COUNT = dtpm_pkg::NODE_COUNT_DEF,
   parameter int ID_BITS    = dtpm_pkg::ID_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dtpm_pkg::REQ_TDATA_BITS-1:0]  req_tdata,   // digit, prefix_id, zero pad
   input  logic                                 req_tlast,
   input  logic [0:0]                           req_tuser,   // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dtpm_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata    // match_id, insert_dropped, pad
);

   localparam int PAD_BITS = dtpm_pkg::RSP_TDATA_BITS - dtpm_pkg::MATCH_ID_BITS - 1;

   logic              front_valid;
   logic              front_ready;
   dtpm_pkg::cmd_type front_cmd;
   logic              queue_valid;
   logic              queue_ready;
   dtpm_pkg::cmd_type queue_cmd;
   logic [dtpm_pkg::MATCH_ID_BITS-1:0] match_id;
   logic              insert_dropped;

   dtpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   dtpm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   dtpm_engine #(
      .NODE_COUNT (NODE_COUNT),
      .ID_BITS    (ID_BITS)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (queue_valid),
      .cmd_ready          (queue_ready),
      .cmd                (queue_cmd),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_match_id       (match_id),
      .rsp_insert_dropped (insert_dropped)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, insert_dropped, match_id};

endmodule

[design/dtpm_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtpm_front
// Request intake: accept a digit request, classify it and hold it in a
// register stage until the queue takes it.
// ---------------------------------------------------------------------------
module dtpm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [dtpm_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  logic                                  req_tlast,
   input  logic [0:0]                            req_tuser,
   output logic                                  cmd_valid,
   input  logic                                  cmd_ready,
   output dtpm_pkg::cmd_type                     cmd
);

   logic              valid_ff;
   logic              valid_in;
   dtpm_pkg::cmd_type cmd_ff;
   dtpm_pkg::cmd_type cmd_in;
   logic [dtpm_pkg::DIGIT_BITS-1:0] digit;

   assign req_tready = !valid_ff || cmd_ready;
   assign digit      = req_tdata[dtpm_pkg::DIGIT_BITS-1:0];

   always_comb begin
      cmd_in.kind      = dtpm_pkg::req_kind_type'(req_tuser[0]);
      cmd_in.digit     = digit;
      cmd_in.digit_ok  = digit < dtpm_pkg::DIGIT_BITS'(dtpm_pkg::DIGITS);
      cmd_in.last      = req_tlast;
      cmd_in.prefix_id = req_tdata[dtpm_pkg::DIGIT_BITS +: dtpm_pkg::PREFIX_ID_BITS];
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

[design/dtpm_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtpm_fifo
// Short command queue between intake and trie engine.
// ---------------------------------------------------------------------------
module dtpm_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dtpm_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dtpm_pkg::cmd_type pop_cmd
);

   localparam int PTR_BITS = (dtpm_pkg::FIFO_DEPTH > 1) ? $clog2(dtpm_pkg::FIFO_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(dtpm_pkg::FIFO_DEPTH + 1);

   dtpm_pkg::cmd_type     slot_ff [dtpm_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != CNT_BITS'(dtpm_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(dtpm_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(dtpm_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/dtpm_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtpm_engine
// Trie walker with a result register: node rows of ten links and ten ids in
// two memories, one row read per digit and written back on insert updates.
// ---------------------------------------------------------------------------
module dtpm_engine #(
   parameter int NODE_COUNT = dtpm_pkg::NODE_COUNT_DEF,
   parameter int ID_BITS    = dtpm_pkg::ID_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  dtpm_pkg::cmd_type                    cmd,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dtpm_pkg::MATCH_ID_BITS-1:0]   rsp_match_id,
   output logic                                 rsp_insert_dropped
);

   localparam int DIGITS    = dtpm_pkg::DIGITS;
   localparam int LINK_BITS = $clog2(NODE_COUNT);
   localparam int LROW_BITS = DIGITS * LINK_BITS;
   localparam int IROW_BITS = DIGITS * ID_BITS;

   logic [LROW_BITS-1:0] link_mem [NODE_COUNT];
   logic [IROW_BITS-1:0] id_mem   [NODE_COUNT];

   dtpm_pkg::eng_state_type state_ff, state_in;
   logic [LINK_BITS-1:0]    clr_cnt_ff, clr_cnt_in;
   dtpm_pkg::cmd_type       cmd_ff;
   logic [LINK_BITS-1:0]    cur_node_ff, cur_node_in;
   logic [LINK_BITS-1:0]    nodes_used_ff, nodes_used_in;
   logic                    walk_ff, walk_in;
   logic [ID_BITS-1:0]      best_ff, best_in;
   logic                    overflow_ff, overflow_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [dtpm_pkg::MATCH_ID_BITS-1:0] rsp_match_ff, rsp_match_in;
   logic                    rsp_drop_ff, rsp_drop_in;
   logic [LROW_BITS-1:0]    link_rd_ff;
   logic [IROW_BITS-1:0]    id_rd_ff;

   logic                    rd_en;
   logic                    wr_en;
   logic [LINK_BITS-1:0]    wr_addr;
   logic [LROW_BITS-1:0]    wr_link_row;
   logic [IROW_BITS-1:0]    wr_id_row;
   logic [LINK_BITS-1:0]    link_sel;
   logic [ID_BITS-1:0]      id_sel;
   logic                    put_link;
   logic                    put_id;
   logic                    out_free;
   logic                    step;
   logic [LINK_BITS-1:0]    new_node;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_node  = nodes_used_ff + 1'b1;
   assign cmd_ready = state_ff == dtpm_pkg::ENG_FETCH;
   assign rd_en     = cmd_valid && cmd_ready;

   always_comb begin
      link_sel = '0;
      id_sel   = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (cmd_ff.digit == dtpm_pkg::DIGIT_BITS'(i)) begin
            link_sel = link_rd_ff[i*LINK_BITS +: LINK_BITS];
            id_sel   = id_rd_ff[i*ID_BITS +: ID_BITS];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      cur_node_in   = cur_node_ff;
      nodes_used_in = nodes_used_ff;
      walk_in       = walk_ff;
      best_in       = best_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_match_in  = rsp_match_ff;
      rsp_drop_in   = rsp_drop_ff;
      put_link      = 1'b0;
      put_id        = 1'b0;
      step          = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cur_node_ff;
      unique case (state_ff)
         dtpm_pkg::ENG_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LINK_BITS'(NODE_COUNT - 1)) begin
               state_in = dtpm_pkg::ENG_FETCH;
            end
         end
         dtpm_pkg::ENG_FETCH: begin
            if (cmd_valid) begin
               state_in = dtpm_pkg::ENG_EXEC;
            end
         end
         dtpm_pkg::ENG_EXEC: begin
            step = !cmd_ff.last || out_free;
            if (step) begin
               state_in = dtpm_pkg::ENG_FETCH;
               if (cmd_ff.kind == dtpm_pkg::REQ_LOOKUP) begin
                  if (walk_ff) begin
                     if (!cmd_ff.digit_ok) begin
                        walk_in = 1'b0;
                     end else begin
                        if (id_sel != '0) begin
                           best_in = id_sel;
                        end
                        if (link_sel != '0) begin
                           cur_node_in = link_sel;
                        end else begin
                           walk_in = 1'b0;
                        end
                     end
                  end
               end else if (cmd_ff.digit_ok && !overflow_ff) begin
                  if (cmd_ff.last) begin
                     put_id = 1'b1;
                  end else if (link_sel != '0) begin
                     cur_node_in = link_sel;
                  end else if (nodes_used_ff != LINK_BITS'(NODE_COUNT - 1)) begin
                     put_link      = 1'b1;
                     nodes_used_in = new_node;
                     cur_node_in   = new_node;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               wr_en = put_link || put_id;
               if (cmd_ff.last) begin
                  rsp_valid_in = 1'b1;
                  rsp_match_in = (cmd_ff.kind == dtpm_pkg::REQ_LOOKUP) ?
                                 dtpm_pkg::MATCH_ID_BITS'(best_in) : '0;
                  rsp_drop_in  = (cmd_ff.kind == dtpm_pkg::REQ_INSERT) && overflow_in;
                  cur_node_in  = '0;
                  walk_in      = 1'b1;
                  best_in      = '0;
                  overflow_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = dtpm_pkg::ENG_CLEAR;
         end
      endcase
   end

   always_comb begin
      wr_link_row = '0;
      wr_id_row   = '0;
      if (state_ff != dtpm_pkg::ENG_CLEAR) begin
         wr_link_row = link_rd_ff;
         wr_id_row   = id_rd_ff;
         for (int i = 0; i < DIGITS; i++) begin
            if (cmd_ff.digit == dtpm_pkg::DIGIT_BITS'(i)) begin
               if (put_link) begin
                  wr_link_row[i*LINK_BITS +: LINK_BITS] = new_node;
               end
               if (put_id) begin
                  wr_id_row[i*ID_BITS +: ID_BITS] = ID_BITS'(cmd_ff.prefix_id);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_link_row;
         id_mem[wr_addr]   <= wr_id_row;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[cur_node_ff];
         id_rd_ff   <= id_mem[cur_node_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtpm_pkg::ENG_CLEAR;
         clr_cnt_ff    <= '0;
         cur_node_ff   <= '0;
         nodes_used_ff <= '0;
         walk_ff       <= 1'b1;
         best_ff       <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cur_node_ff   <= cur_node_in;
         nodes_used_ff <= nodes_used_in;
         walk_ff       <= walk_in;
         best_ff       <= best_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (rd_en) begin
         cmd_ff <= cmd;
      end
      rsp_match_ff <= rsp_match_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_id       = rsp_match_ff;
   assign rsp_insert_dropped = rsp_drop_ff;

endmodule

[design/dtpm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtpm_checker
// Port-level checks of the trie prefix match unit, bound to the top level.
// ---------------------------------------------------------------------------
module dtpm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [dtpm_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && (rsp_tdata[15:0] != 16'd0)))
      else $error("dropped insert reported with a match id");

   a_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

endmodule

bind decimal_trie_prefix_match_unit dtpm_checker u_dtpm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/tb_decimal_trie_prefix_match_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_decimal_trie_prefix_match_unit
// Streams insert and lookup digits into the decimal trie unit and checks
// every response against a behavioral trie kept in the bench: longest-match
// lookups, erased ids, out-of-range digits, interleaved request kinds and a
// stalled response side.
// ---------------------------------------------------------------------------
module tb_decimal_trie_prefix_match_unit;

   localparam int NODES       = dtpm_pkg::NODE_COUNT_DEF;
   localparam int SLOTS       = NODES * dtpm_pkg::DIGITS;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_PAD   = 8;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      bit [dtpm_pkg::MATCH_ID_BITS-1:0] match_id;
      bit                               dropped;
   } trie_answer_type;

   logic                                clock;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [dtpm_pkg::REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                                req_tlast  = 1'b0;
   logic [0:0]                          req_tuser  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [dtpm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;

   // trie held by the bench
   bit [11:0]                          link_mem [0:SLOTS-1];
   bit [dtpm_pkg::ID_BITS_DEF-1:0]     id_mem   [0:SLOTS-1];
   int unsigned                        nodes_alloc;
   int unsigned                        cursor;
   bit                                 walking;
   bit [dtpm_pkg::MATCH_ID_BITS-1:0]   best_match;
   bit                                 store_full;

   trie_answer_type  match_queue [$];
   trie_answer_type  head_answer;
   bit [3:0]         number_buf [$];
   int               error_count;
   int               items_sent;
   int               cycle_count;
   int               hold_left;
   int               rsp_wait;
   bit               idle_on;

   decimal_trie_prefix_match_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      end
      error_count++;
   endtask

   task automatic restart_walk();
      cursor     = 0;
      walking    = 1'b1;
      best_match = '0;
      store_full = 1'b0;
   endtask

   task automatic walk_trie(input dtpm_pkg::req_kind_type kind, input bit [3:0] digit,
                            input bit last,
                            input bit [dtpm_pkg::PREFIX_ID_BITS-1:0] id);
      int unsigned     slot;
      trie_answer_type answer;
      slot = cursor * dtpm_pkg::DIGITS + digit;
      if (kind == dtpm_pkg::REQ_INSERT) begin
         if (digit < dtpm_pkg::DIGITS && !store_full) begin
            if (last) begin
               id_mem[slot] = id[dtpm_pkg::ID_BITS_DEF-1:0];
            end else begin
               if (link_mem[slot] == 0) begin
                  if (nodes_alloc + 1 < NODES) begin
                     nodes_alloc++;
                     link_mem[slot] = 12'(nodes_alloc);
                  end else begin
                     store_full = 1'b1;
                  end
               end
               if (!store_full) cursor = link_mem[slot];
            end
         end
      end else if (walking) begin
         if (digit >= dtpm_pkg::DIGITS) begin
            walking = 1'b0;
         end else begin
            if (id_mem[slot] != 0) best_match = id_mem[slot];
            if (link_mem[slot] != 0) cursor = link_mem[slot];
            else walking = 1'b0;
         end
      end
      if (last) begin
         answer.match_id = (kind == dtpm_pkg::REQ_LOOKUP) ? best_match : '0;
         answer.dropped  = (kind == dtpm_pkg::REQ_INSERT) ? store_full : 1'b0;
         match_queue = {match_queue, answer};
         restart_walk();
      end
   endtask

   task automatic send_digit(input dtpm_pkg::req_kind_type kind, input bit [3:0] digit,
                             input bit last,
                             input bit [dtpm_pkg::PREFIX_ID_BITS-1:0] id);
      int gap;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, id, digit};
      req_tuser  <= kind;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      walk_trie(kind, digit, last, id);
      items_sent++;
   endtask

   task automatic send_number(input dtpm_pkg::req_kind_type kind,
                              input bit [dtpm_pkg::PREFIX_ID_BITS-1:0] id);
      int n;
      n = number_buf.size();
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) send_digit(kind, number_buf[i], 1'b1, id);
         else send_digit(kind, number_buf[i], 1'b0, dtpm_pkg::PREFIX_ID_BITS'($urandom));
      end
   endtask

   task automatic wait_for_answers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (match_queue.size() != 0) @(negedge clock);
   endtask

   function automatic bit [3:0] pick_digit();
      int r;
      r = $urandom_range(0, 31);
      if (r < 20) return 4'($urandom_range(0, 3));
      if (r < 30) return 4'($urandom_range(0, 9));
      return 4'($urandom_range(10, 15));
   endfunction

   function automatic bit [dtpm_pkg::PREFIX_ID_BITS-1:0] pick_id();
      if ($urandom_range(0, 15) == 0) return '0;
      return dtpm_pkg::PREFIX_ID_BITS'($urandom_range(1, 65535));
   endfunction

   task automatic test_longest_match();
      number_buf = '{4'd1};
      send_number(dtpm_pkg::REQ_INSERT, 16'd100);
      number_buf = '{4'd1, 4'd2};
      send_number(dtpm_pkg::REQ_INSERT, 16'd200);
      number_buf = '{4'd1, 4'd2, 4'd3};
      send_number(dtpm_pkg::REQ_INSERT, 16'hFFFF);
      number_buf = '{4'd1, 4'd2, 4'd3, 4'd9};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd1, 4'd2, 4'd9};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd5};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd0, 4'd8};
      send_number(dtpm_pkg::REQ_INSERT, 16'h0001);
      number_buf = '{4'd0, 4'd8, 4'd8};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      wait_for_answers();
   endtask

   task automatic test_zero_id_and_bad_digits();
      // erase a stored prefix by writing id zero
      number_buf = '{4'd1, 4'd2};
      send_number(dtpm_pkg::REQ_INSERT, '0);
      number_buf = '{4'd1, 4'd2, 4'd3};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd1, 4'd2, 4'd5};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      // skip out-of-range digits on insert, end the walk on lookup
      number_buf = '{4'd9, 4'd15, 4'd8};
      send_number(dtpm_pkg::REQ_INSERT, 16'h5A5A);
      number_buf = '{4'd9, 4'd8};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd1, 4'd10, 4'd2, 4'd3};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      number_buf = '{4'd12};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      wait_for_answers();
   endtask

   task automatic test_mixed_kinds();
      send_digit(dtpm_pkg::REQ_INSERT, 4'd4, 1'b0, 16'h1111);
      send_digit(dtpm_pkg::REQ_LOOKUP, 4'd5, 1'b0, 16'h2222);
      send_digit(dtpm_pkg::REQ_INSERT, 4'd6, 1'b1, 16'h1234);
      send_digit(dtpm_pkg::REQ_LOOKUP, 4'd1, 1'b0, '0);
      send_digit(dtpm_pkg::REQ_INSERT, 4'd7, 1'b0, '0);
      send_digit(dtpm_pkg::REQ_LOOKUP, 4'd2, 1'b1, '0);
      number_buf = '{4'd4, 4'd6};
      send_number(dtpm_pkg::REQ_LOOKUP, '0);
      wait_for_answers();
   endtask

   task automatic test_random(input int item_goal);
      int start_count;
      int pick;
      int len;
      start_count = items_sent;
      while (items_sent - start_count < item_goal) begin
         if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            len = $urandom_range(1, 5);
            number_buf = {};
            repeat (len) number_buf = {number_buf, pick_digit()};
            send_number(dtpm_pkg::REQ_INSERT, pick_id());
         end else if (pick < 17) begin
            len = $urandom_range(1, 7);
            number_buf = {};
            repeat (len) number_buf = {number_buf, pick_digit()};
            send_number(dtpm_pkg::REQ_LOOKUP, dtpm_pkg::PREFIX_ID_BITS'($urandom));
         end else begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               send_digit(dtpm_pkg::req_kind_type'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)),
                          $urandom_range(0, 3) == 0,
                          dtpm_pkg::PREFIX_ID_BITS'($urandom));
            end
         end
      end
      wait_for_answers();
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 400;
      idle_on   = 1'b0;
      repeat (30) begin
         number_buf = '{pick_digit()};
         send_number(dtpm_pkg::req_kind_type'($urandom_range(0, 1)), pick_id());
      end
      wait_for_answers();
      idle_on = 1'b1;
   endtask

   // response side: hold off for a long stretch on request, else per-response waits
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_queue.size() == 0) begin
            report_mismatch("response with none pending", rsp_tdata, 0);
         end else begin
            head_answer = match_queue.pop_front();
            if (rsp_tdata[dtpm_pkg::MATCH_ID_BITS-1:0] != head_answer.match_id) begin
               report_mismatch("match_id", rsp_tdata[dtpm_pkg::MATCH_ID_BITS-1:0],
                               head_answer.match_id);
            end
            if (rsp_tdata[dtpm_pkg::MATCH_ID_BITS] != head_answer.dropped) begin
               report_mismatch("insert_dropped", rsp_tdata[dtpm_pkg::MATCH_ID_BITS],
                               head_answer.dropped);
            end
         end
         rsp_wait = idle_on ? $urandom_range(0, 16) : 0;
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      error_count = 0;
      items_sent  = 0;
      hold_left   = 0;
      rsp_wait    = 0;
      idle_on     = 1'b1;
      nodes_alloc = 0;
      restart_walk();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_longest_match();
      test_zero_id_and_bad_digits();
      test_mixed_kinds();
      test_random(880);
      test_backpressure();

      repeat (DRAIN_PAD) @(posedge clock);
      if (match_queue.size() != 0) begin
         report_mismatch("responses never returned", match_queue.size(), 0);
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
